/* rtl/rcvp_pkg.sv */
// ----------------------------------------------------------------------------
// rcvp_pkg
// shared types, constants and tables of the cube vertex projector
// ----------------------------------------------------------------------------
package rcvp_pkg;

   localparam int ANGLE_W  = 6;
   localparam int TABLE_STEPS = 64;
   localparam int QUARTER  = TABLE_STEPS / 4;
   localparam int SINE_W   = 10;
   localparam int TRIG_W   = 8;
   localparam int ROT_W    = 9;
   localparam int DIST_W   = 10;
   localparam int DEPTH_W  = 12;
   localparam int NUM_W    = 16;
   localparam int SUM_W    = NUM_W + 1;
   localparam int SCR_W    = 10;
   localparam int IDX_W    = 3;
   localparam int DIV_CNT_W = $clog2(NUM_W);

   localparam logic [DIST_W-1:0] CAM_RESET = DIST_W'(300);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(7);

   localparam logic signed [NUM_W-1:0] X_SCALE  = NUM_W'(80);
   localparam logic signed [NUM_W-1:0] Y_NUMER  = NUM_W'(64 * 70);
   localparam logic signed [SUM_W-1:0] X_CENTER = SUM_W'(80);
   localparam logic signed [SUM_W-1:0] Y_CENTER = SUM_W'(72);
   localparam logic signed [SUM_W-1:0] SCR_MAX  = SUM_W'(511);
   localparam logic signed [SUM_W-1:0] SCR_MIN  = -SUM_W'(512);

   localparam logic signed [SINE_W-1:0] SINE_LUT [TABLE_STEPS] = '{
      10'sd0,    10'sd25,   10'sd50,   10'sd74,   10'sd98,   10'sd120,  10'sd142,  10'sd162,
      10'sd181,  10'sd197,  10'sd212,  10'sd225,  10'sd236,  10'sd244,  10'sd250,  10'sd254,
      10'sd256,  10'sd254,  10'sd250,  10'sd244,  10'sd236,  10'sd225,  10'sd212,  10'sd197,
      10'sd181,  10'sd162,  10'sd142,  10'sd120,  10'sd98,   10'sd74,   10'sd50,   10'sd25,
      10'sd0,   -10'sd25,  -10'sd50,  -10'sd74,  -10'sd98,  -10'sd120, -10'sd142, -10'sd162,
     -10'sd181, -10'sd197, -10'sd212, -10'sd225, -10'sd236, -10'sd244, -10'sd250, -10'sd254,
     -10'sd256, -10'sd254, -10'sd250, -10'sd244, -10'sd236, -10'sd225, -10'sd212, -10'sd197,
     -10'sd181, -10'sd162, -10'sd142, -10'sd120, -10'sd98,  -10'sd74,  -10'sd50,  -10'sd25
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START_X,
      ST_WAIT_X,
      ST_START_Y,
      ST_WAIT_Y,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic advance;
      logic start_div;
      logic sel_y;
      logic latch_x;
      logic load_out;
      logic next_vertex;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic last_vertex;
      logic out_free;
   } status_type;

   // quarter-scaled trig value, floor division by 4
   function automatic logic signed [TRIG_W-1:0] trig_at(input logic [ANGLE_W-1:0] angle);
      logic signed [SINE_W-1:0] raw;
      raw = SINE_LUT[angle];
      return TRIG_W'(raw >>> 2);
   endfunction

   function automatic logic signed [SCR_W-1:0] sat_screen(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] c;
      if (v > SCR_MAX) begin
         c = SCR_MAX;
      end else if (v < SCR_MIN) begin
         c = SCR_MIN;
      end else begin
         c = v;
      end
      return c[SCR_W-1:0];
   endfunction

endpackage

/* rtl/rcvp_ifs.sv */
// ----------------------------------------------------------------------------
// rcvp channel interfaces
// request, response and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface rcvp_req_if;
   logic valid;
   logic ready;
   logic frame_tick;

   modport source (output valid, output frame_tick, input ready);
   modport sink   (input valid, input frame_tick, output ready);
endinterface

interface rcvp_rsp_if import rcvp_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [IDX_W-1:0]         vertex_index;
   logic signed [SCR_W-1:0]  screen_x;
   logic signed [SCR_W-1:0]  screen_y;
   logic                     last_vertex;

   modport source (output valid, output vertex_index, output screen_x, output screen_y,
                   output last_vertex, input ready);
   modport sink   (input valid, input vertex_index, input screen_x, input screen_y,
                   input last_vertex, output ready);
endinterface

interface rcvp_csr_if import rcvp_pkg::*;;
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] camera_distance;

   modport source (output valid, output camera_distance, input ready);
   modport sink   (input valid, input camera_distance, output ready);
endinterface

/* rtl/rcvp_div.sv */
// ----------------------------------------------------------------------------
// rcvp_div
// signed restoring divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module rcvp_div import rcvp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [NUM_W-1:0]   numer,
   input  logic signed [DEPTH_W-1:0] denom,
   output logic                      done,
   output logic signed [NUM_W-1:0]   quo
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0]     shift_ff, shift_in;
   logic [DEPTH_W-1:0]   rem_ff, rem_in;
   logic [DEPTH_W-1:0]   den_ff, den_in;
   logic                 neg_ff, neg_in;
   logic                 zero_ff, zero_in;

   logic [NUM_W-1:0]     numer_mag;
   logic [DEPTH_W-1:0]   denom_mag;
   logic [DEPTH_W:0]     trial;
   logic                 fits;

   assign numer_mag = numer[NUM_W-1] ? NUM_W'(-numer) : NUM_W'(numer);
   assign denom_mag = denom[DEPTH_W-1] ? DEPTH_W'(-denom) : DEPTH_W'(denom);
   assign trial     = {rem_ff, shift_ff[NUM_W-1]};
   assign fits      = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = numer_mag;
         rem_in   = '0;
         den_in   = denom_mag;
         neg_in   = numer[NUM_W-1] ^ denom[DEPTH_W-1];
         zero_in  = (denom == '0);
      end else if (busy_ff) begin
         rem_in   = fits ? DEPTH_W'(trial - {1'b0, den_ff}) : trial[DEPTH_W-1:0];
         shift_in = {shift_ff[NUM_W-2:0], fits};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      neg_ff   <= neg_in;
      zero_ff  <= zero_in;
   end

   assign done = done_ff;
   assign quo  = zero_ff ? '0 : (neg_ff ? -$signed(shift_ff) : $signed(shift_ff));

endmodule

/* rtl/rcvp_datapath.sv */
// ----------------------------------------------------------------------------
// rcvp_datapath
// angle and trig registers, corner rotation, shared divider, output register
// ----------------------------------------------------------------------------
module rcvp_datapath import rcvp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic                     csr_valid,
   input  logic [DIST_W-1:0]        csr_camera_distance,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [IDX_W-1:0]         rsp_vertex_index,
   output logic signed [SCR_W-1:0]  rsp_screen_x,
   output logic signed [SCR_W-1:0]  rsp_screen_y,
   output logic                     rsp_last_vertex
);

   logic [ANGLE_W-1:0]        angle_ff, angle_in;
   logic signed [TRIG_W-1:0]  s4_ff, s4_in;
   logic signed [TRIG_W-1:0]  c4_ff, c4_in;
   logic [DIST_W-1:0]         cam_dist_ff, cam_dist_in;
   logic [IDX_W-1:0]          vtx_ff, vtx_in;
   logic signed [SCR_W-1:0]   px_ff, px_in;
   logic                      out_valid_ff, out_valid_in;
   logic [IDX_W-1:0]          out_idx_ff, out_idx_in;
   logic signed [SCR_W-1:0]   out_x_ff, out_x_in;
   logic signed [SCR_W-1:0]   out_y_ff, out_y_in;
   logic                      out_last_ff, out_last_in;

   logic [ANGLE_W-1:0]        angle_next;
   logic                      xneg, yneg, zneg;
   logic signed [ROT_W-1:0]   s9, c9, rx, rz;
   logic signed [DEPTH_W-1:0] depth;
   logic signed [NUM_W-1:0]   numer_x, numer_y, numer;
   logic                      div_done;
   logic signed [NUM_W-1:0]   quo;
   logic                      out_free;

   // corner signs follow the corner number
   assign xneg = vtx_ff[0] ^ vtx_ff[1];
   assign yneg = vtx_ff[1];
   assign zneg = vtx_ff[2];

   assign s9 = ROT_W'(s4_ff);
   assign c9 = ROT_W'(c4_ff);
   assign rx = (xneg ? -c9 : c9) - (zneg ? -s9 : s9);
   assign rz = (xneg ? -s9 : s9) + (zneg ? -c9 : c9);
   assign depth = DEPTH_W'(rz) + $signed(DEPTH_W'(cam_dist_ff));

   assign numer_x = NUM_W'(rx) * X_SCALE;
   assign numer_y = yneg ? -Y_NUMER : Y_NUMER;
   assign numer   = cmd.sel_y ? numer_y : numer_x;

   rcvp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.start_div),
      .numer (numer),
      .denom (depth),
      .done  (div_done),
      .quo   (quo)
   );

   assign angle_next = angle_ff + 1'b1;
   assign out_free   = !out_valid_ff || rsp_ready;

   always_comb begin
      angle_in     = angle_ff;
      s4_in        = s4_ff;
      c4_in        = c4_ff;
      cam_dist_in  = cam_dist_ff;
      vtx_in       = vtx_ff;
      px_in        = px_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_idx_in   = out_idx_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_last_in  = out_last_ff;
      if (csr_valid) begin
         cam_dist_in = csr_camera_distance;
      end
      if (cmd.advance) begin
         angle_in = angle_next;
         s4_in    = trig_at(angle_next);
         c4_in    = trig_at(angle_next + ANGLE_W'(QUARTER));
         vtx_in   = '0;
      end
      if (cmd.latch_x) begin
         px_in = sat_screen(SUM_W'(quo) + X_CENTER);
      end
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         out_idx_in   = vtx_ff;
         out_x_in     = px_ff;
         out_y_in     = sat_screen(Y_CENTER - SUM_W'(quo));
         out_last_in  = (vtx_ff == LAST_IDX);
      end
      if (cmd.next_vertex) begin
         vtx_in = vtx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff     <= '0;
         cam_dist_ff  <= CAM_RESET;
         vtx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         angle_ff     <= angle_in;
         cam_dist_ff  <= cam_dist_in;
         vtx_ff       <= vtx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s4_ff       <= s4_in;
      c4_ff       <= c4_in;
      px_ff       <= px_in;
      out_idx_ff  <= out_idx_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_last_ff <= out_last_in;
   end

   assign status.div_done    = div_done;
   assign status.last_vertex = (vtx_ff == LAST_IDX);
   assign status.out_free    = out_free;

   assign rsp_valid        = out_valid_ff;
   assign rsp_vertex_index = out_idx_ff;
   assign rsp_screen_x     = out_x_ff;
   assign rsp_screen_y     = out_y_ff;
   assign rsp_last_vertex  = out_last_ff;

endmodule

/* rtl/rcvp_ctrl.sv */
// ----------------------------------------------------------------------------
// rcvp_ctrl
// frame sequencer: two divisions per corner, then hand the point to the output
// ----------------------------------------------------------------------------
module rcvp_ctrl import rcvp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_frame_tick,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_frame_tick) begin
               cmd.advance = 1'b1;
               state_in    = ST_START_X;
            end
         end
         ST_START_X: begin
            cmd.start_div = 1'b1;
            state_in      = ST_WAIT_X;
         end
         ST_WAIT_X: begin
            if (status.div_done) begin
               cmd.latch_x = 1'b1;
               state_in    = ST_START_Y;
            end
         end
         ST_START_Y: begin
            cmd.sel_y     = 1'b1;
            cmd.start_div = 1'b1;
            state_in      = ST_WAIT_Y;
         end
         ST_WAIT_Y: begin
            if (status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               if (status.last_vertex) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.next_vertex = 1'b1;
                  state_in        = ST_START_X;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/rotating_cube_vertex_projector_core.sv */
// ----------------------------------------------------------------------------
// rotating_cube_vertex_projector_core
// rotates a cube about the y axis and projects its eight corners to the screen
// ----------------------------------------------------------------------------
// A transfer on the request channel with frame_tick set advances the 6-bit
// angle, looks up sine and cosine (quarter scale) and produces eight screen
// points, corners 0 to 7, the last one flagged. A transfer with frame_tick
// clear is taken and ignored. After the tick is taken, each corner runs
// a division for x and then one for y on the single shared divider, which
// runs one quotient bit per cycle over 16 steps, and then loads the output
// register once the response side is free. Requests are taken only between
// frames. The output register lets the last point wait while the next tick
// is taken.
// camera_distance resets to 300 and is written through the csr channel,
// which is always ready; write it only while no frame is in progress. A
// depth of zero yields a zero quotient; results saturate to -512..511.
// ----------------------------------------------------------------------------
module rotating_cube_vertex_projector_core import rcvp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   rcvp_req_if.sink      req_chan,
   rcvp_rsp_if.source    rsp_chan,
   rcvp_csr_if.sink      csr_chan
);

   cmd_type    cmd;
   status_type status;

   // register writes never stall
   assign csr_chan.ready = 1'b1;

   // sequencer: one frame at a time, two divisions per corner
   rcvp_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_frame_tick (req_chan.frame_tick),
      .req_ready      (req_chan.ready),
      .status         (status),
      .cmd            (cmd)
   );

   // angle, trig, rotation, divider and output register
   rcvp_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_valid           (csr_chan.valid),
      .csr_camera_distance (csr_chan.camera_distance),
      .rsp_valid           (rsp_chan.valid),
      .rsp_ready           (rsp_chan.ready),
      .rsp_vertex_index    (rsp_chan.vertex_index),
      .rsp_screen_x        (rsp_chan.screen_x),
      .rsp_screen_y        (rsp_chan.screen_y),
      .rsp_last_vertex     (rsp_chan.last_vertex)
   );

endmodule
